FILE: hdl/xrpc_pkg.sv
// shared types and constants for the xor range pair counter
package xrpc_pkg;

  localparam int EPOCH_BITS = 8;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WIPE,
    ST_START,
    ST_WALK,
    ST_SUM,
    ST_INS,
    ST_DONE
  } state_t;

  typedef enum logic {
    REG_RANGE_LOW,
    REG_RANGE_HIGH
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic clearing;
    logic ins_issue;
    logic load_out;
  } ctl_t;

endpackage

FILE: hdl/xrpc_mem.sv
// prefix counter memory, one write port and two registered read ports
module xrpc_mem #(
  parameter int ADDR_BITS = 17,
  parameter int DATA_BITS = 24,
  parameter int DEPTH     = 131070
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr_a,
  input  logic [ADDR_BITS-1:0] rd_addr_b,
  output logic [DATA_BITS-1:0] rd_data_a,
  output logic [DATA_BITS-1:0] rd_data_b
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: hdl/xrpc_walk.sv
// one trie walk: counts stored values whose xor with the value is at most the bound
module xrpc_walk #(
  parameter int VALUE_BITS = 16,
  parameter int COUNT_BITS = 16,
  parameter int ACC_BITS   = 21
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic [VALUE_BITS-1:0]                     value,
  input  logic [VALUE_BITS-1:0]                     bound,
  input  logic [xrpc_pkg::EPOCH_BITS-1:0]           epoch,
  output logic [VALUE_BITS:0]                       rd_addr,
  input  logic [COUNT_BITS+xrpc_pkg::EPOCH_BITS-1:0] rd_data,
  output logic [ACC_BITS-1:0]                       acc,
  output logic                                      done
);

  localparam int AW = VALUE_BITS + 1;
  localparam int SW = $clog2(VALUE_BITS + 2);
  localparam int EB = xrpc_pkg::EPOCH_BITS;
  localparam int DW = COUNT_BITS + EB;

  logic                  act_r;
  logic                  pend_r;
  logic                  addf_r;
  logic                  fin_r;
  logic                  done_r;
  logic [SW-1:0]         s_r;
  logic [VALUE_BITS-1:0] vs_r;
  logic [VALUE_BITS-1:0] ts_r;
  logic [VALUE_BITS-1:0] pre_r;
  logic [ACC_BITS-1:0]   acc_r;

  logic                  vb;
  logic                  tb;
  logic                  last;
  logic                  addf;
  logic [SW-1:0]         sel;
  logic [AW-1:0]         base;
  logic [AW-1:0]         cand;
  logic [COUNT_BITS-1:0] cnt;

  always_comb begin
    vb   = vs_r[VALUE_BITS-1];
    tb   = ts_r[VALUE_BITS-1];
    last = (s_r == SW'(VALUE_BITS + 1));
    sel  = last ? SW'(VALUE_BITS) : s_r;
    base = (AW'(1) << sel) - AW'(2);
    cand = last ? {1'b0, pre_r} : {pre_r, vb};
    rd_addr = base + cand;
    addf = last | tb;
    cnt  = (rd_data[DW-1 -: EB] == epoch) ? rd_data[COUNT_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        act_r <= 1'b1;
      end else if (act_r && last) begin
        act_r <= 1'b0;
      end
      pend_r <= act_r && !start;
      done_r <= pend_r && fin_r;
    end
  end

  always_ff @(posedge clk) begin
    addf_r <= addf;
    fin_r  <= last;
    if (start) begin
      s_r   <= SW'(1);
      vs_r  <= value;
      ts_r  <= bound;
      pre_r <= '0;
      acc_r <= '0;
    end else begin
      if (act_r) begin
        s_r   <= s_r + SW'(1);
        vs_r  <= {vs_r[VALUE_BITS-2:0], 1'b0};
        ts_r  <= {ts_r[VALUE_BITS-2:0], 1'b0};
        pre_r <= {pre_r[VALUE_BITS-2:0], vb ^ tb};
      end
      if (pend_r && addf_r) begin
        acc_r <= acc_r + ACC_BITS'(cnt);
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

FILE: hdl/xor_range_pair_counter.sv
// xor range pair counter top level: control, insert path, config registers
// one item at a time: in_ready stays low through the walk and the insert pass over the
// single write port of the counter memory, and while a finished result waits on out_ready
// reset: synchronous, then a clearing pass over all 2^(VALUE_BITS+1)-2 nodes (131070)
// with in_ready low; the same pass runs on every 256th set started by a first item
module xor_range_pair_counter #(
  parameter int VALUE_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_value,
  input  logic        in_first,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_item_pairs,
  output logic [31:0] out_running_total,
  output logic        out_last_out,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int VB         = VALUE_BITS;
  localparam int AW         = VB + 1;
  localparam int NODE_COUNT = (2 << VB) - 2;
  localparam int EB         = xrpc_pkg::EPOCH_BITS;
  localparam int DW         = COUNT_BITS + EB;
  localparam int SW         = $clog2(VB + 1);
  localparam int ACC_BITS   = COUNT_BITS + $clog2(VB + 2);
  localparam int WB         = (VB > 16) ? VB : 16;
  localparam int PW         = (ACC_BITS > 16) ? ACC_BITS : 16;

  xrpc_pkg::state_t state_r, state_nxt;
  xrpc_pkg::ctl_t   ctl;

  logic [15:0]     range_low_r;
  logic [15:0]     range_high_r;
  logic [EB-1:0]   epoch_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [31:0]     total_r;
  logic [VB-1:0]   v_r;
  logic            last_r;
  logic [15:0]     pairs_r;
  logic            out_valid_r;
  logic [15:0]     out_pairs_r;
  logic [31:0]     out_total_r;
  logic            out_last_r;
  logic [SW-1:0]   ins_s_r;
  logic [VB-1:0]   ins_pre_r;
  logic [VB-1:0]   ins_vs_r;
  logic            wr_pend_r;
  logic [AW-1:0]   wr_addr_r;

  logic            accept;
  logic            clr_last;
  logic            ins_last;
  logic            cfg_write;
  logic [WB-1:0]   mask_ext;
  logic [WB-1:0]   hi_ext;
  logic [WB-1:0]   lo_ext;
  logic [15:0]     lo_m1;
  logic [VB-1:0]   hi_t;
  logic [VB-1:0]   lo_t;
  logic [AW-1:0]   ins_addr;
  logic [AW-1:0]   hi_addr;
  logic [AW-1:0]   lo_addr;
  logic [AW-1:0]   rd_addr_a;
  logic [DW-1:0]   rd_data_a;
  logic [DW-1:0]   rd_data_b;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [DW-1:0]   mem_wd;
  logic [COUNT_BITS-1:0] ins_cnt;
  logic [COUNT_BITS-1:0] ins_new;
  logic [ACC_BITS-1:0]   hi_acc;
  logic [ACC_BITS-1:0]   lo_acc;
  logic [ACC_BITS-1:0]   lo_eff;
  logic [ACC_BITS-1:0]   diff;
  logic [PW-1:0]         diff_ext;
  logic [15:0]           pairs;
  logic [32:0]           sum;
  logic                  hi_done;
  logic                  lo_done;

  assign accept    = in_valid && in_ready;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign clr_last  = (clr_cnt_r == AW'(NODE_COUNT - 1));
  assign ins_last  = (ins_s_r == SW'(VB));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xrpc_pkg::ST_INIT: begin
        if (clr_last) state_nxt = xrpc_pkg::ST_IDLE;
      end
      xrpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_first && (epoch_r == {EB{1'b1}})) state_nxt = xrpc_pkg::ST_WIPE;
          else state_nxt = xrpc_pkg::ST_START;
        end
      end
      xrpc_pkg::ST_WIPE: begin
        if (clr_last) state_nxt = xrpc_pkg::ST_START;
      end
      xrpc_pkg::ST_START: state_nxt = xrpc_pkg::ST_WALK;
      xrpc_pkg::ST_WALK: begin
        if (hi_done) state_nxt = xrpc_pkg::ST_SUM;
      end
      xrpc_pkg::ST_SUM: state_nxt = xrpc_pkg::ST_INS;
      xrpc_pkg::ST_INS: begin
        if (ins_last) state_nxt = xrpc_pkg::ST_DONE;
      end
      xrpc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = xrpc_pkg::ST_IDLE;
      end
      default: state_nxt = xrpc_pkg::ST_INIT;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready      = (state_r == xrpc_pkg::ST_IDLE);
    ctl.start     = (state_r == xrpc_pkg::ST_START);
    ctl.clearing  = (state_r == xrpc_pkg::ST_INIT) || (state_r == xrpc_pkg::ST_WIPE);
    ctl.ins_issue = (state_r == xrpc_pkg::ST_INS);
    ctl.load_out  = (state_r == xrpc_pkg::ST_DONE) && (!out_valid_r || out_ready);
  end

  // search bounds, clamped to the value width
  always_comb begin
    mask_ext = WB'({VB{1'b1}});
    hi_ext   = WB'(range_high_r);
    lo_m1    = range_low_r - 16'd1;
    lo_ext   = WB'(lo_m1);
    hi_t     = (hi_ext > mask_ext) ? {VB{1'b1}} : VB'(hi_ext);
    lo_t     = (lo_ext > mask_ext) ? {VB{1'b1}} : VB'(lo_ext);
  end

  // pair count from the two walks, and the running total sum
  always_comb begin
    lo_eff   = (range_low_r == 16'd0) ? '0 : lo_acc;
    diff     = (hi_acc > lo_eff) ? (hi_acc - lo_eff) : '0;
    diff_ext = PW'(diff);
    pairs    = (diff_ext > PW'(16'hFFFF)) ? 16'hFFFF : diff_ext[15:0];
    sum      = {1'b0, total_r} + 33'(pairs_r);
  end

  // insert path: read node, write back its saturating incremented count next cycle; clearing writes zeros instead
  always_comb begin
    ins_addr = ((AW'(1) << ins_s_r) - AW'(2)) + {ins_pre_r, ins_vs_r[VB-1]};
    ins_cnt  = (rd_data_a[DW-1 -: EB] == epoch_r) ? rd_data_a[COUNT_BITS-1:0] : '0;
    ins_new  = (ins_cnt == {COUNT_BITS{1'b1}}) ? ins_cnt : ins_cnt + COUNT_BITS'(1);
    rd_addr_a = ctl.ins_issue ? ins_addr : hi_addr;
    if (ctl.clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_pend_r;
      mem_wa = wr_addr_r;
      mem_wd = {epoch_r, ins_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= xrpc_pkg::ST_INIT;
      range_low_r  <= 16'd1;
      range_high_r <= 16'hFFFF;
      epoch_r      <= '0;
      clr_cnt_r    <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      wr_pend_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) begin
        case (xrpc_pkg::reg_idx_t'(cfg_paddr[2]))
          xrpc_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_pwdata[15:0];
          xrpc_pkg::REG_RANGE_HIGH: range_high_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (ctl.clearing) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      if (accept && in_first) begin
        epoch_r <= epoch_r + EB'(1);
        total_r <= '0;
      end else if (state_r == xrpc_pkg::ST_SUM) begin
        total_r <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      wr_pend_r <= ctl.ins_issue;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r    <= VB'(in_value);
      last_r <= in_last_in;
    end
    if (hi_done) begin
      pairs_r <= pairs;
    end
    if (state_r == xrpc_pkg::ST_SUM) begin
      ins_s_r   <= SW'(1);
      ins_pre_r <= '0;
      ins_vs_r  <= v_r;
    end else if (ctl.ins_issue) begin
      ins_s_r   <= ins_s_r + SW'(1);
      ins_pre_r <= {ins_pre_r[VB-2:0], ins_vs_r[VB-1]};
      ins_vs_r  <= {ins_vs_r[VB-2:0], 1'b0};
    end
    wr_addr_r <= ins_addr;
    if (ctl.load_out) begin
      out_pairs_r <= pairs_r;
      out_total_r <= total_r;
      out_last_r  <= last_r;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (xrpc_pkg::reg_idx_t'(cfg_paddr[2]))
      xrpc_pkg::REG_RANGE_LOW:  cfg_prdata = {16'd0, range_low_r};
      xrpc_pkg::REG_RANGE_HIGH: cfg_prdata = {16'd0, range_high_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign cfg_pready        = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_item_pairs    = out_pairs_r;
  assign out_running_total = out_total_r;
  assign out_last_out      = out_last_r;

  xrpc_walk #(
    .VALUE_BITS (VB),
    .COUNT_BITS (COUNT_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_walk_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctl.start),
    .value   (v_r),
    .bound   (hi_t),
    .epoch   (epoch_r),
    .rd_addr (hi_addr),
    .rd_data (rd_data_a),
    .acc     (hi_acc),
    .done    (hi_done)
  );

  xrpc_walk #(
    .VALUE_BITS (VB),
    .COUNT_BITS (COUNT_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_walk_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctl.start),
    .value   (v_r),
    .bound   (lo_t),
    .epoch   (epoch_r),
    .rd_addr (lo_addr),
    .rd_data (rd_data_b),
    .acc     (lo_acc),
    .done    (lo_done)
  );

  xrpc_mem #(
    .ADDR_BITS (AW),
    .DATA_BITS (DW),
    .DEPTH     (NODE_COUNT)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .wr_addr   (mem_wa),
    .wr_data   (mem_wd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (lo_addr),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

`ifndef NO_ASSERTIONS
  a_walks_align: assert property (@(posedge clk) disable iff (!rst_n)
    hi_done == lo_done)
    else $error("walks out of step");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xrpc_pkg::ST_IDLE |-> !mem_we)
    else $error("memory write while idle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == xrpc_pkg::ST_DONE)
    else $error("result raised outside done");

  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    hi_done |-> state_r == xrpc_pkg::ST_WALK)
    else $error("walk finished outside walk state");
`endif

endmodule
